// ===== hdl/triple_tap_ensemble_chorus_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the three-tap ensemble chorus
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TRIPLE_TAP_ENSEMBLE_CHORUS_TOP_ASSERT_SVH
`define TRIPLE_TAP_ENSEMBLE_CHORUS_TOP_ASSERT_SVH

// same-cycle implication
`define TTEC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ttec_pkg.sv =====
// ---------------------------------------------------------------------------
// ttec_pkg
// Shared constants, types and the quarter-wave sine table of the chorus.
// ---------------------------------------------------------------------------
package ttec_pkg;

    localparam int RING_DEPTH       = 1024;
    localparam int SAMPLE_BITS      = 24;
    localparam int PHASE_BITS       = 24;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_IW = SINE_AW + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int COEF_W     = 18;
    localparam int STEP_W     = 20;
    localparam int CENTER_W   = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_C1     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C2     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_D0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FSTEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SSTEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd5;

    localparam logic [COEF_W-1:0]   C1_RST     = 18'd138936;
    localparam logic [COEF_W-1:0]   C2_RST     = 18'd48431;
    localparam logic [COEF_W-1:0]   D0_RST     = 18'd25690;
    localparam logic [STEP_W-1:0]   FSTEP_RST  = 20'd1992;
    localparam logic [STEP_W-1:0]   SSTEP_RST  = 20'd175;
    localparam logic [CENTER_W-1:0] CENTER_RST = 17'd24576;

    // shared multiplier operand widths
    localparam int MUL_AW = (SAMPLE_BITS + 3 > 33) ? SAMPLE_BITS + 3 : 33;
    localparam int MUL_BW = SAMPLE_BITS + 4;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // reciprocal of 3, exact for magnitudes below 2^(SAMPLE_BITS+1)
    localparam int RECIP_SH = SAMPLE_BITS + 3;
    localparam longint RECIP3 = ((64'sd1 <<< RECIP_SH) + 2) / 3;

    localparam logic [15:0] FAST_W [0:2] = '{16'd13304, 16'd16253, 16'd16515};
    localparam logic [15:0] SLOW_W [0:2] = '{16'd41615, 16'd48824, 16'd39911};

    localparam logic [PHASE_BITS-1:0] TAP_OFF [0:2] = '{
        PHASE_BITS'(0),
        PHASE_BITS'((64'd1 << PHASE_BITS) / 3),
        PHASE_BITS'(((64'd1 << PHASE_BITS) * 2) / 3)
    };

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1073741824;

    // Taylor series denominators (2n)(2n+1)
    localparam longint SER_D1 = 64'sd6;
    localparam longint SER_D2 = 64'sd20;
    localparam longint SER_D3 = 64'sd42;
    localparam longint SER_D4 = 64'sd72;
    localparam longint SER_D5 = 64'sd110;
    localparam longint SER_D6 = 64'sd156;

    typedef logic [16:0] t_sine_tab [0:SINE_TABLE_DEPTH];

    typedef struct packed {
        logic                     en;
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                   we;
        logic [RING_AW-1:0]     waddr;
        logic [SAMPLE_BITS-1:0] wdata;
        logic                   re;
        logic [RING_AW-1:0]     raddr;
    } t_ring_req;

    // Q30 Taylor series, evaluated at elaboration only
    function automatic t_sine_tab build_sine();
        t_sine_tab tab;
        longint x;
        longint x2;
        longint term;
        longint sum;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = HALF_PI_Q30 * k / SINE_TABLE_DEPTH;
            x2   = x * x / Q30_ONE;
            term = x;
            sum  = x;
            term = -((term * x2 / Q30_ONE) / SER_D1);
            sum  = sum + term;
            term = -((term * x2 / Q30_ONE) / SER_D2);
            sum  = sum + term;
            term = -((term * x2 / Q30_ONE) / SER_D3);
            sum  = sum + term;
            term = -((term * x2 / Q30_ONE) / SER_D4);
            sum  = sum + term;
            term = -((term * x2 / Q30_ONE) / SER_D5);
            sum  = sum + term;
            term = -((term * x2 / Q30_ONE) / SER_D6);
            sum  = sum + term;
            if (sum < 0) sum = 0;
            if (sum > Q30_ONE) sum = Q30_ONE;
            tab[k] = 17'((sum + 8192) >>> 14);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

    function automatic logic signed [17:0] sine_q16(input logic [PHASE_BITS-1:0] ph);
        logic [1:0]         quad;
        logic [SINE_IW-1:0] idx;
        logic signed [17:0] v;
        quad = ph[PHASE_BITS-1 -: 2];
        idx  = {1'b0, ph[PHASE_BITS-3 -: SINE_AW]};
        if (quad[0]) idx = SINE_IW'(SINE_TABLE_DEPTH) - idx;
        v = $signed({1'b0, SINE_TAB[idx]});
        return quad[1] ? -v : v;
    endfunction

endpackage

// ===== hdl/ttec_if.sv =====
// ---------------------------------------------------------------------------
// ttec_if
// Valid/ready sample channels: input and result.
// ---------------------------------------------------------------------------
interface ttec_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ttec_pkg::SAMPLE_BITS-1:0] audio_in;
    logic                                  frame_last;

    modport source (output valid, output audio_in, output frame_last, input ready);
    modport sink   (input valid, input audio_in, input frame_last, output ready);
endinterface

interface ttec_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ttec_pkg::SAMPLE_BITS-1:0] audio_out;
    logic                                  frame_last_out;

    modport source (output valid, output audio_out, output frame_last_out, input ready);
    modport sink   (input valid, input audio_out, input frame_last_out, output ready);
endinterface

// ===== hdl/ttec_ring.sv =====
// ---------------------------------------------------------------------------
// ttec_ring
// Delay ring memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ttec_ring (
    input  logic                                   i_clk,
    input  ttec_pkg::t_ring_req                    i_req,
    output logic signed [ttec_pkg::SAMPLE_BITS-1:0] o_rdata
);

    logic [ttec_pkg::SAMPLE_BITS-1:0] mem [0:ttec_pkg::RING_DEPTH-1];
    logic [ttec_pkg::SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = $signed(r_rdata);

endmodule

// ===== hdl/ttec_mul.sv =====
// ---------------------------------------------------------------------------
// ttec_mul
// Shared signed multiplier with registered product.
// ---------------------------------------------------------------------------
module ttec_mul (
    input  logic                                  i_clk,
    input  ttec_pkg::t_mul_req                    i_req,
    output logic signed [ttec_pkg::MUL_PW-1:0]    o_prod
);

    logic signed [ttec_pkg::MUL_PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/triple_tap_ensemble_chorus_top.sv =====
// One beat at a time: input ready is high only while idle, so a new beat is taken
// only after the last result is loaded; every product goes through one shared
// multiplier and each tap reads the delay ring twice over its one read port.
// Reset: synchronous, active low; a sweep then zeroes every ring entry and
// input ready stays low meanwhile. Config writes are taken in any cycle.
// ---------------------------------------------------------------------------
// triple_tap_ensemble_chorus_top
// SVF lowpass into a delay ring, three LFO-modulated interpolated taps,
// averaged and saturated. Sequenced over one multiplier.
// ---------------------------------------------------------------------------
module triple_tap_ensemble_chorus_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ttec_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ttec_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    ttec_in_if.sink                             i_audio,
    ttec_out_if.source                          o_audio
);

    localparam int S  = ttec_pkg::SAMPLE_BITS;
    localparam int AW = ttec_pkg::RING_AW;
    localparam int PB = ttec_pkg::PHASE_BITS;
    localparam int AB = ttec_pkg::MUL_AW;
    localparam int BB = ttec_pkg::MUL_BW;

    localparam logic [4:0] ST_CLR  = 5'd0;
    localparam logic [4:0] ST_IDLE = 5'd1;
    localparam logic [4:0] ST_X    = 5'd2;
    localparam logic [4:0] ST_LOW  = 5'd3;
    localparam logic [4:0] ST_BAND = 5'd4;
    localparam logic [4:0] ST_WR   = 5'd5;
    localparam logic [4:0] ST_PH   = 5'd6;
    localparam logic [4:0] ST_SF   = 5'd7;
    localparam logic [4:0] ST_SS   = 5'd8;
    localparam logic [4:0] ST_M    = 5'd9;
    localparam logic [4:0] ST_DLY  = 5'd10;
    localparam logic [4:0] ST_ADDR = 5'd11;
    localparam logic [4:0] ST_RD1  = 5'd12;
    localparam logic [4:0] ST_DIFF = 5'd13;
    localparam logic [4:0] ST_FR   = 5'd14;
    localparam logic [4:0] ST_TAP  = 5'd15;
    localparam logic [4:0] ST_DIV  = 5'd16;
    localparam logic [4:0] ST_Q    = 5'd17;
    localparam logic [4:0] ST_OUT  = 5'd18;

    localparam logic [1:0] LAST_TAP = 2'd2;

    localparam logic signed [35:0] MAX32 = 36'sd2147483647;
    localparam logic signed [35:0] MIN32 = -36'sd2147483648;
    localparam logic signed [35:0] MAXS  = 36'((64'sd1 <<< (S - 1)) - 1);
    localparam logic signed [35:0] MINS  = 36'(-(64'sd1 <<< (S - 1)));

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > MAX32) return 32'(MAX32);
        if (v < MIN32) return 32'(MIN32);
        return 32'(v);
    endfunction

    function automatic logic signed [S-1:0] sat_smp(input logic signed [35:0] v);
        if (v > MAXS) return S'(MAXS);
        if (v < MINS) return S'(MINS);
        return S'(v);
    endfunction

    // config
    logic [ttec_pkg::COEF_W-1:0]   r_c1, r_c2, r_d0;
    logic [ttec_pkg::STEP_W-1:0]   r_fstep, r_sstep;
    logic [ttec_pkg::CENTER_W-1:0] r_center;

    // control and state
    logic [4:0]                r_state, n_state;
    logic [AW-1:0]             r_clr;
    logic [AW-1:0]             r_widx;
    logic [PB-1:0]             r_fph, r_sph;
    logic [1:0]                r_tap;
    logic signed [31:0]        r_band, r_low, r_x;
    logic signed [S-1:0]       r_samp;
    logic                      r_last;
    logic signed [17:0]        r_sf, r_ss;
    logic signed [35:0]        r_macc;
    logic [17:0]               r_mul;
    logic [7:0]                r_frac;
    logic [AW-1:0]             r_i0;
    logic signed [S-1:0]       r_s0;
    logic signed [S:0]         r_diff;
    logic signed [S+2:0]       r_acc;
    logic                      r_neg;
    logic signed [S-1:0]       r_res;
    logic                      r_ovalid;
    logic signed [S-1:0]       r_oaudio;
    logic                      r_olast;

    ttec_pkg::t_mul_req                 w_mreq;
    ttec_pkg::t_ring_req                w_rreq;
    logic signed [ttec_pkg::MUL_PW-1:0] w_prod;
    logic signed [S-1:0]                w_rdata;

    logic signed [35:0]   w_sh16;
    logic signed [35:0]   w_msum;
    logic signed [19:0]   w_mulv;
    logic [AW-1:0]        w_n;
    logic [7:0]           w_frac;
    logic signed [S+2:0]  w_tap;
    logic [S+1:0]         w_abs;
    logic signed [S+1:0]  w_q;
    logic                 w_load;

    ttec_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mreq),
        .o_prod (w_prod)
    );

    ttec_ring u_ring (
        .i_clk   (i_clk),
        .i_req   (w_rreq),
        .o_rdata (w_rdata)
    );

    // delay product is Q.24: integer part above bit 24, fraction in bits 23:16
    assign w_sh16 = 36'(w_prod >>> 16);
    assign w_msum = r_macc + 36'(w_prod);
    assign w_mulv = 20'sd65536 + 20'(w_msum >>> 16);
    assign w_n    = w_prod[24 +: AW];
    assign w_frac = w_prod[16 +: 8];
    assign w_tap  = (S+3)'(r_s0) + (S+3)'(w_prod >>> 8);
    assign w_abs  = r_acc[S+2] ? (S+2)'(-r_acc) : (S+2)'(r_acc);
    assign w_q    = $signed({1'b0, w_prod[ttec_pkg::RECIP_SH +: S+1]});
    assign w_load = (r_state == ST_OUT) && (!r_ovalid || o_audio.ready);

    assign i_audio.ready          = (r_state == ST_IDLE);
    assign o_audio.valid          = r_ovalid;
    assign o_audio.audio_out      = r_oaudio;
    assign o_audio.frame_last_out = r_olast;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR:  if (r_clr == '1) n_state = ST_IDLE;
            ST_IDLE: if (i_audio.valid) n_state = ST_X;
            ST_X:    n_state = ST_LOW;
            ST_LOW:  n_state = ST_BAND;
            ST_BAND: n_state = ST_WR;
            ST_WR:   n_state = ST_PH;
            ST_PH:   n_state = ST_SF;
            ST_SF:   n_state = ST_SS;
            ST_SS:   n_state = ST_M;
            ST_M:    n_state = ST_DLY;
            ST_DLY:  n_state = ST_ADDR;
            ST_ADDR: n_state = ST_RD1;
            ST_RD1:  n_state = ST_DIFF;
            ST_DIFF: n_state = ST_FR;
            ST_FR:   n_state = ST_TAP;
            ST_TAP:  n_state = (r_tap == LAST_TAP) ? ST_DIV : ST_PH;
            ST_DIV:  n_state = ST_Q;
            ST_Q:    n_state = ST_OUT;
            ST_OUT:  if (w_load) n_state = ST_IDLE;
            default: n_state = ST_CLR;
        endcase
    end

    always_comb begin
        w_mreq    = '0;
        w_mreq.en = 1'b1;
        case (r_state)
            ST_X: begin
                w_mreq.a = AB'(r_band);
                w_mreq.b = BB'(r_c2);
            end
            ST_LOW: begin
                w_mreq.a = AB'(r_x);
                w_mreq.b = BB'(r_c1);
            end
            ST_BAND: begin
                w_mreq.a = AB'(r_x);
                w_mreq.b = BB'(r_d0);
            end
            ST_SF: begin
                w_mreq.a = AB'(r_sf);
                w_mreq.b = BB'(ttec_pkg::FAST_W[r_tap]);
            end
            ST_SS: begin
                w_mreq.a = AB'(r_ss);
                w_mreq.b = BB'(ttec_pkg::SLOW_W[r_tap]);
            end
            ST_DLY: begin
                w_mreq.a = AB'(r_center);
                w_mreq.b = BB'(r_mul);
            end
            ST_FR: begin
                w_mreq.a = AB'(r_diff);
                w_mreq.b = BB'(r_frac);
            end
            ST_DIV: begin
                w_mreq.a = AB'(w_abs);
                w_mreq.b = BB'(ttec_pkg::RECIP3);
            end
            default: w_mreq.en = 1'b0;
        endcase
    end

    always_comb begin
        w_rreq = '0;
        case (r_state)
            ST_CLR: begin
                w_rreq.we    = 1'b1;
                w_rreq.waddr = r_clr;
            end
            ST_WR: begin
                w_rreq.we    = 1'b1;
                w_rreq.waddr = r_widx;
                w_rreq.wdata = sat_smp(w_sh16 + 36'(r_low));
            end
            ST_ADDR: begin
                w_rreq.re    = 1'b1;
                w_rreq.raddr = r_widx - w_n;
            end
            ST_RD1: begin
                w_rreq.re    = 1'b1;
                w_rreq.raddr = r_i0 - AW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1     <= ttec_pkg::C1_RST;
            r_c2     <= ttec_pkg::C2_RST;
            r_d0     <= ttec_pkg::D0_RST;
            r_fstep  <= ttec_pkg::FSTEP_RST;
            r_sstep  <= ttec_pkg::SSTEP_RST;
            r_center <= ttec_pkg::CENTER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ttec_pkg::CFG_C1:     r_c1     <= i_cfg_data[ttec_pkg::COEF_W-1:0];
                ttec_pkg::CFG_C2:     r_c2     <= i_cfg_data[ttec_pkg::COEF_W-1:0];
                ttec_pkg::CFG_D0:     r_d0     <= i_cfg_data[ttec_pkg::COEF_W-1:0];
                ttec_pkg::CFG_FSTEP:  r_fstep  <= i_cfg_data[ttec_pkg::STEP_W-1:0];
                ttec_pkg::CFG_SSTEP:  r_sstep  <= i_cfg_data[ttec_pkg::STEP_W-1:0];
                ttec_pkg::CFG_CENTER: r_center <= i_cfg_data[ttec_pkg::CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_widx   <= '0;
            r_fph    <= '0;
            r_sph    <= '0;
            r_band   <= '0;
            r_low    <= '0;
            r_tap    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_audio.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLR: r_clr <= r_clr + AW'(1);
                ST_IDLE: begin
                    if (i_audio.valid) begin
                        r_samp <= i_audio.audio_in;
                        r_last <= i_audio.frame_last;
                        r_fph  <= r_fph + PB'(r_fstep);
                        r_sph  <= r_sph + PB'(r_sstep);
                    end
                end
                ST_X:    r_x    <= sat32(36'(r_samp) - 36'(r_band) - 36'(r_low));
                ST_LOW:  r_low  <= sat32(36'(r_low) + w_sh16);
                ST_BAND: r_band <= sat32(36'(r_band) + w_sh16);
                ST_WR: begin
                    r_acc <= '0;
                    r_tap <= '0;
                end
                ST_PH: begin
                    r_sf <= ttec_pkg::sine_q16(r_fph + ttec_pkg::TAP_OFF[r_tap]);
                    r_ss <= ttec_pkg::sine_q16(r_sph + ttec_pkg::TAP_OFF[r_tap]);
                end
                ST_SS:   r_macc <= 36'(w_prod);
                ST_M:    r_mul  <= w_mulv[17:0];
                ST_ADDR: begin
                    r_i0   <= r_widx - w_n;
                    r_frac <= w_frac;
                end
                ST_RD1:  r_s0   <= w_rdata;
                ST_DIFF: r_diff <= (S+1)'(w_rdata) - (S+1)'(r_s0);
                ST_TAP: begin
                    r_acc <= r_acc + w_tap;
                    r_tap <= r_tap + 2'd1;
                end
                ST_DIV:  r_neg <= r_acc[S+2];
                ST_Q:    r_res <= sat_smp(r_neg ? -36'(w_q) : 36'(w_q));
                ST_OUT: begin
                    if (w_load) begin
                        r_oaudio <= r_res;
                        r_olast  <= r_last;
                        r_widx   <= r_widx + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/ttec_checker.sv =====
// ---------------------------------------------------------------------------
// ttec_checker
// Port-level checks on the chorus top, attached by bind.
// ---------------------------------------------------------------------------
`include "triple_tap_ensemble_chorus_top_assert.svh"

module ttec_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ttec_pkg::SAMPLE_BITS-1:0] i_out_audio
);

    // one beat in flight: busy right after a beat is taken
    `TTEC_ASSERT_NEXT(a_busy_after_beat, i_in_valid && i_in_ready, !i_in_ready, "ready after beat")
    // a result appears only out of a busy sequence
    `TTEC_ASSERT_NOW(a_result_from_busy, $rose(i_out_valid), $past(!i_in_ready), "result while idle")
    `TTEC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "valid dropped")
    `TTEC_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_audio), "data moved")

endmodule

bind triple_tap_ensemble_chorus_top ttec_checker u_ttec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_audio.valid),
    .i_in_ready  (i_audio.ready),
    .i_out_valid (o_audio.valid),
    .i_out_ready (o_audio.ready),
    .i_out_audio (o_audio.audio_out)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: three-tap ensemble chorus testbench
// Drives samples through valid/ready channels and keeps its own bit-exact
// model of the filter, the delay ring, the LFOs and the interpolated taps.
// Each result beat is checked in order. Register settings change between
// phases while the block is idle. Idling on both sides is varied by phase.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CFG_IDX_W        = ttec_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W       = ttec_pkg::CFG_DATA_W;
    localparam int SAMPLE_BITS      = ttec_pkg::SAMPLE_BITS;
    localparam int PHASE_BITS       = ttec_pkg::PHASE_BITS;
    localparam int RING_DEPTH       = ttec_pkg::RING_DEPTH;
    localparam int RING_AW          = ttec_pkg::RING_AW;
    localparam int SINE_TABLE_DEPTH = ttec_pkg::SINE_TABLE_DEPTH;
    localparam int SINE_AW          = ttec_pkg::SINE_AW;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int NUM_REGS  = 6;
    localparam int DRAIN_CYC = 60;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] audio;
        logic                          last;
    } t_chorus_beat;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ttec_in_if  in_if();
    ttec_out_if out_if();

    triple_tap_ensemble_chorus_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_audio    (in_if),
        .o_audio    (out_if)
    );

    // model state
    logic [CFG_DATA_W-1:0] reg_val [0:NUM_REGS-1];
    int                    reg_width [0:NUM_REGS-1] = '{18, 18, 18, 20, 20, 17};
    longint                band_acc, low_acc;
    longint                ring_mem [0:RING_DEPTH-1];
    logic [RING_AW-1:0]    wr_ptr;
    logic [PHASE_BITS-1:0] fast_ph, slow_ph;
    longint                quarter_sine [0:SINE_TABLE_DEPTH];

    t_chorus_beat expected_q [$];
    int send_idle_pct;
    int recv_stall_pct;
    int n_sent, n_checked, n_errors;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat_sample(longint v);
        return clamp(v, -(64'sd1 <<< (SAMPLE_BITS - 1)), (64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    endfunction

    function automatic void fill_sine();
        longint x, x2, term, acc;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = 64'sd1686629713 * k / SINE_TABLE_DEPTH;
            x2   = x * x / 64'sd1073741824;
            term = x;
            acc  = x;
            for (int n = 1; n <= 6; n++) begin
                term = -((term * x2 / 64'sd1073741824) / longint'((2 * n) * (2 * n + 1)));
                acc  = acc + term;
            end
            acc = clamp(acc, 0, 64'sd1073741824);
            quarter_sine[k] = (acc + 8192) >>> 14;
        end
    endfunction

    function automatic longint lfo_sine(logic [PHASE_BITS-1:0] ph);
        int idx;
        idx = ph[PHASE_BITS-3 -: SINE_AW];
        if (ph[PHASE_BITS-2]) idx = SINE_TABLE_DEPTH - idx;
        return ph[PHASE_BITS-1] ? -quarter_sine[idx] : quarter_sine[idx];
    endfunction

    function automatic longint tap_read(int t);
        longint wf [0:2] = '{13304, 16253, 16515};
        longint ws [0:2] = '{41615, 48824, 39911};
        logic [PHASE_BITS-1:0] off;
        longint m, dly, s0, s1;
        int n, frac, i0, i1;
        off  = PHASE_BITS'(((64'd1 << PHASE_BITS) * t) / 3);
        m    = (wf[t] * lfo_sine(fast_ph + off) + ws[t] * lfo_sine(slow_ph + off)) >>> 16;
        dly  = (longint'(reg_val[ttec_pkg::CFG_CENTER]) * (65536 + m)) >>> 16;
        if (dly < 0) dly = 0;
        n    = (dly >> 8) % RING_DEPTH;
        frac = dly & 255;
        i0   = (int'(wr_ptr) + RING_DEPTH - n) % RING_DEPTH;
        i1   = (i0 + RING_DEPTH - 1) % RING_DEPTH;
        s0   = ring_mem[i0];
        s1   = ring_mem[i1];
        return s0 + (((s1 - s0) * frac) >>> 8);
    endfunction

    function automatic t_chorus_beat chorus_predict(logic signed [SAMPLE_BITS-1:0] smp,
                                                    logic last);
        t_chorus_beat r;
        longint x, band_old, acc;
        fast_ph  = fast_ph + PHASE_BITS'(reg_val[ttec_pkg::CFG_FSTEP]);
        slow_ph  = slow_ph + PHASE_BITS'(reg_val[ttec_pkg::CFG_SSTEP]);
        band_old = band_acc;
        x        = clamp(longint'(smp) - band_acc - low_acc, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        low_acc  = clamp(low_acc + ((longint'(reg_val[ttec_pkg::CFG_C2]) * band_old) >>> 16),
                         -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        band_acc = clamp(band_acc + ((longint'(reg_val[ttec_pkg::CFG_C1]) * x) >>> 16),
                         -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        ring_mem[wr_ptr] = sat_sample(((longint'(reg_val[ttec_pkg::CFG_D0]) * x) >>> 16)
                                      + low_acc);
        acc = 0;
        for (int t = 0; t < 3; t++) acc += tap_read(t);
        r.audio = SAMPLE_BITS'(sat_sample(acc / 3));
        r.last  = last;
        wr_ptr  = wr_ptr + 1'b1;
        return r;
    endfunction

    // result checker and receiver stall
    always @(posedge i_clk) begin
        t_chorus_beat exp_beat;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected beat: audio %0d last %0b",
                             out_if.audio_out, out_if.frame_last_out);
            end else begin
                exp_beat = expected_q.pop_front();
                n_checked++;
                if (exp_beat.audio !== out_if.audio_out
                        || exp_beat.last !== out_if.frame_last_out) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("beat %0d mismatch: exp audio %0d last %0b, got %0d %0b",
                                 n_checked, exp_beat.audio, exp_beat.last,
                                 out_if.audio_out, out_if.frame_last_out);
                end
            end
        end
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp, logic last);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.audio_in   <= smp;
        in_if.frame_last <= last;
        do @(posedge i_clk); while (!in_if.ready);
        expected_q.push_back(chorus_predict(smp, last));
        n_sent++;
    endtask

    task automatic drain();
        @(posedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < NUM_REGS)
            reg_val[idx] = data & ((20'd1 << reg_width[idx]) - 1);
    endtask

    task automatic set_all(logic [CFG_DATA_W-1:0] c1, logic [CFG_DATA_W-1:0] c2,
                           logic [CFG_DATA_W-1:0] d0, logic [CFG_DATA_W-1:0] fs,
                           logic [CFG_DATA_W-1:0] ss, logic [CFG_DATA_W-1:0] ctr);
        write_reg(ttec_pkg::CFG_C1, c1);
        write_reg(ttec_pkg::CFG_C2, c2);
        write_reg(ttec_pkg::CFG_D0, d0);
        write_reg(ttec_pkg::CFG_FSTEP, fs);
        write_reg(ttec_pkg::CFG_SSTEP, ss);
        write_reg(ttec_pkg::CFG_CENTER, ctr);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_value(int w);
        case ($urandom_range(5))
            0: return '0;
            1: return (20'd1 << w) - 1;
            2: return $urandom;
            default: return $urandom_range((1 << w) - 1);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2: return $signed(SAMPLE_BITS'($urandom_range(255))) - 128;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // defaults from reset, field extremes and sign changes
        send_sample(24'sh7fffff, 1'b0);
        send_sample(-24'sh800000, 1'b1);
        send_sample('0, 1'b0);
        send_sample(-24'sd1, 1'b1);
        send_sample(24'sh555555, 1'b0);
        send_sample(24'shaaaaaa, 1'b1);
        drain();
        // filter saturation with maximal gains, wide writes and unused indexes
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        set_all('1, '1, '1, '1, '1, '1);
        for (int i = 0; i < 8; i++)
            send_sample(i[0] ? -24'sh800000 : 24'sh7fffff, i[1]);
        drain();
        // long center wraps the ring, zero steps freeze the LFOs
        set_all(ttec_pkg::C1_RST, ttec_pkg::C2_RST, ttec_pkg::D0_RST, '0, '0, 20'd130816);
        for (int i = 0; i < 5; i++) send_sample(pick_sample(), i[0]);
        drain();
        set_all(ttec_pkg::C1_RST, ttec_pkg::C2_RST, ttec_pkg::D0_RST,
                ttec_pkg::FSTEP_RST, ttec_pkg::SSTEP_RST, '0);
        for (int i = 0; i < 5; i++) send_sample(pick_sample(), i[0]);
        drain();
    endtask

    task automatic test_random_phase(int count, int idle, int stall, logic extreme_cfg);
        if (extreme_cfg) begin
            set_all(pick_value(18), pick_value(18), pick_value(18),
                    pick_value(20), pick_value(20), pick_value(17));
        end else begin
            set_all($urandom_range(262143), $urandom_range(131071), $urandom_range(65535),
                    $urandom_range(4095), $urandom_range(511), $urandom_range(130816));
        end
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            send_sample(pick_sample(), $urandom_range(1));
            if (i == count / 2 && stall == 0) begin
                // hold the sender until every result is back
                @(posedge i_clk);
                in_if.valid <= 1'b0;
                while (expected_q.size() != 0) @(posedge i_clk);
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.audio_in   = '0;
        in_if.frame_last = 1'b0;
        out_if.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        fill_sine();
        reg_val  = '{ttec_pkg::C1_RST, ttec_pkg::C2_RST, ttec_pkg::D0_RST,
                     ttec_pkg::FSTEP_RST, ttec_pkg::SSTEP_RST, ttec_pkg::CENTER_RST};
        band_acc = 0;
        low_acc  = 0;
        foreach (ring_mem[i]) ring_mem[i] = 0;
        wr_ptr  = '0;
        fast_ph = '0;
        slow_ph = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phase(100, 0, 0, 1'b0);
        test_random_phase(100, 60, 0, 1'b1);
        test_random_phase(100, 0, 60, 1'b0);
        test_random_phase(100, 15, 15, 1'b1);
        test_random_phase(100, 0, 0, 1'b1);
        test_random_phase(80, 15, 15, 1'b0);

        $display("covered %0d samples, %0d results checked, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("register extremes, filter saturation, ring wrap and idle mixes exercised");
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
